### rtl/mbd_pkg.sv
// Shared types and constants for the multi-button debouncer.
package mbd_pkg;

  localparam int MASK_W     = 5;
  localparam int SEL_W      = 3;
  localparam int NOW_W      = 32;
  localparam int HELD_W     = 32;
  localparam int DEB_W      = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_SETTLE_DOWN = 2'd1,
    PH_DOWN        = 2'd2,
    PH_SETTLE_UP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_INJ_MASK  = 2'd1,
    REG_INJ_LEVEL = 2'd2
  } reg_idx_t;

  // What one button lane reports for the item in flight.
  typedef struct packed {
    logic down;
    logic pressed;
    logic released;
  } lane_stat_t;

endpackage

### rtl/mbd_lane.sv
// One button's debounce state machine with its phase and press timestamps.
module mbd_lane
  import mbd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 raw,
  input  logic [TIME_BITS-1:0] now,
  input  logic [DEB_W-1:0]     debounce,
  output lane_stat_t           stat,
  output logic [HELD_W-1:0]    held
);

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] phase_start_r, phase_start_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic [TIME_BITS-1:0] phase_age;
  logic [TIME_BITS-1:0] press_age;
  logic                 elapsed;
  logic                 press_edge;
  logic                 release_edge;

  // Wrap-safe age: modular subtraction, then compare against the hold time.
  assign phase_age = now - phase_start_r;
  assign press_age = now - press_start_r;
  assign elapsed   = phase_age >= TIME_BITS'(debounce);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (raw) phase_nxt = PH_SETTLE_DOWN;
      end
      PH_SETTLE_DOWN: begin
        if (!raw) phase_nxt = PH_IDLE;
        else if (elapsed) phase_nxt = PH_DOWN;
      end
      PH_DOWN: begin
        if (!raw) phase_nxt = PH_SETTLE_UP;
      end
      PH_SETTLE_UP: begin
        if (raw) phase_nxt = PH_DOWN;
        else if (elapsed) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    press_edge      = (phase_r == PH_SETTLE_DOWN) && raw && elapsed;
    release_edge    = (phase_r == PH_SETTLE_UP) && !raw && elapsed;
    phase_start_nxt = phase_start_r;
    press_start_nxt = press_start_r;
    // A bounce back to down keeps both timestamps untouched.
    if (((phase_r == PH_IDLE) && raw) || ((phase_r == PH_DOWN) && !raw) ||
        press_edge || release_edge) begin
      phase_start_nxt = now;
    end
    if (press_edge) press_start_nxt = now;
    stat.down     = (phase_nxt == PH_DOWN) || (phase_nxt == PH_SETTLE_UP);
    stat.pressed  = press_edge;
    stat.released = release_edge;
    if (!stat.down || press_edge) held = '0;
    else held = HELD_W'(press_age);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      phase_start_r <= phase_start_nxt;
      press_start_r <= press_start_nxt;
    end
  end

endmodule

### rtl/mbd_merge.sv
// Gathers the lane reports into the result masks and picks the held time.
module mbd_merge
  import mbd_pkg::*;
#(
  parameter int BUTTONS = 5
) (
  input  lane_stat_t        stat [BUTTONS],
  input  logic [HELD_W-1:0] held_lane [BUTTONS],
  input  logic [SEL_W-1:0]  held_select,
  output logic [MASK_W-1:0] down_mask,
  output logic [MASK_W-1:0] pressed_mask,
  output logic [MASK_W-1:0] released_mask,
  output logic [HELD_W-1:0] held_time
);

  always_comb begin
    down_mask     = '0;
    pressed_mask  = '0;
    released_mask = '0;
    held_time     = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (i < MASK_W) begin
        down_mask[i % MASK_W]     = stat[i].down;
        pressed_mask[i % MASK_W]  = stat[i].pressed;
        released_mask[i % MASK_W] = stat[i].released;
      end
      // A select past the last lane matches nothing and reads zero.
      if (held_select == SEL_W'(i)) held_time = held_lane[i];
    end
  end

endmodule

### rtl/multi_button_debouncer_core.sv
// Top level of the multi-button debouncer: registers, lanes, merge and output stage.
//
// Each input item is one poll: a millisecond timestamp, the active-low pins of
// the buttons and the index of the button whose held time is wanted. Every
// button has its own lane, a four-phase debouncer (idle, settling down, down,
// settling up) that compares the age of its current phase against
// debounce_time by modular subtraction, so timestamp wrap is harmless. All
// lanes update together in the cycle the poll is accepted, and the merged
// result (down, press-edge and release-edge masks plus the held time of the
// selected button) appears in the output register on the next cycle. The
// block takes one item per clock; the only stall is a full output register
// whose item is not being taken that cycle. Configuration sits on an APB
// port: debounce_time at 0x0, inject_mask at 0x4 and inject_level at 0x8. A
// set inject_mask bit makes that button see inject_level instead of its pin.
// Buttons beyond the fifth have no pin or injection bit, read as pressed and
// are left out of the masks.
module multi_button_debouncer_core
  import mbd_pkg::*;
#(
  parameter int BUTTONS   = 5,
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: now_time[31:0], pin_levels[36:32], held_select[39:37]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: down_mask[4:0], pressed_mask[9:5], released_mask[14:10],
  // held_time[46:15], zero[47]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [DEB_W-1:0]      debounce_r;
  logic [MASK_W-1:0]     inj_mask_r;
  logic [MASK_W-1:0]     inj_level_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  logic [NOW_W-1:0]      now_time;
  logic [MASK_W-1:0]     pin_levels;
  logic [SEL_W-1:0]      held_select;
  logic [TIME_BITS-1:0]  now;
  logic                  in_accept;
  logic [BUTTONS-1:0]    raw;
  lane_stat_t            stat [BUTTONS];
  logic [HELD_W-1:0]     held_lane [BUTTONS];

  logic [MASK_W-1:0]     down_mask;
  logic [MASK_W-1:0]     pressed_mask;
  logic [MASK_W-1:0]     released_mask;
  logic [HELD_W-1:0]     held_time;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Configuration port. Register index comes from the word address.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RESET;
      inj_mask_r  <= '0;
      inj_level_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:  debounce_r  <= cfg_pwdata[DEB_W-1:0];
        REG_INJ_MASK:  inj_mask_r  <= cfg_pwdata[MASK_W-1:0];
        REG_INJ_LEVEL: inj_level_r <= cfg_pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE:  cfg_prdata = CFG_DATA_W'(debounce_r);
      REG_INJ_MASK:  cfg_prdata = CFG_DATA_W'(inj_mask_r);
      REG_INJ_LEVEL: cfg_prdata = CFG_DATA_W'(inj_level_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Input unpacking. The timestamp is taken modulo 2^TIME_BITS.
  assign now_time    = in_tdata[31:0];
  assign pin_levels  = in_tdata[36:32];
  assign held_select = in_tdata[39:37];
  assign now         = TIME_BITS'(now_time);

  // The output register frees up whenever its item is taken, so a new poll
  // can enter in the same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    if (i < MASK_W) begin : g_pin
      assign raw[i] = inj_mask_r[i] ? inj_level_r[i] : !pin_levels[i];
    end else begin : g_nopin
      assign raw[i] = 1'b1;
    end

    mbd_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_en  (in_accept),
      .raw      (raw[i]),
      .now      (now),
      .debounce (debounce_r),
      .stat     (stat[i]),
      .held     (held_lane[i])
    );
  end

  mbd_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .stat          (stat),
    .held_lane     (held_lane),
    .held_select   (held_select),
    .down_mask     (down_mask),
    .pressed_mask  (pressed_mask),
    .released_mask (released_mask),
    .held_time     (held_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {1'b0, held_time, released_mask, pressed_mask, down_mask};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the multi-button debouncer core: directed table plus random polls.
module tb_top;
  import mbd_pkg::*;

  // Generous cycle budget: roughly 1900 polls in the worst pacing still fit
  // many times over.
  localparam int RUN_LIMIT = 500000;
  localparam int RAND_PHASES = 8;
  localparam int POLLS_PER_PHASE = 231;

  // The register map has three words; the fourth word address decodes to
  // nothing and a write there must leave every register alone.
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 4'hC;

  // One result item as it is unpacked from out_tdata.
  typedef struct packed {
    logic [MASK_W-1:0] down;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [HELD_W-1:0] held;
  } poll_report_t;

  // One row of the directed table: either a register write or a poll. A poll
  // row may carry a hand-written expectation that replaces the predictor's.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    logic [NOW_W-1:0]      now;
    logic [MASK_W-1:0]     pins;
    logic [SEL_W-1:0]      sel;
    logic                  typed;
    poll_report_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata: now_time[31:0], pin_levels[36:32], held_select[39:37]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: down_mask[4:0], pressed_mask[9:5], released_mask[14:10],
  // held_time[46:15], zero[47]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  multi_button_debouncer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the block: per-button phase and the two timestamps,
  // plus the three configuration registers at their reset values.
  phase_t            btn_phase   [MASK_W];
  logic [NOW_W-1:0]  phase_t0    [MASK_W];
  logic [NOW_W-1:0]  press_t0    [MASK_W];
  logic [DEB_W-1:0]  debounce_ms = DEBOUNCE_RESET;
  logic [MASK_W-1:0] inj_mask_r  = '0;
  logic [MASK_W-1:0] inj_level_r = '0;

  initial begin
    for (int i = 0; i < MASK_W; i++) begin
      btn_phase[i] = PH_IDLE;
      phase_t0[i]  = '0;
      press_t0[i]  = '0;
    end
  end

  poll_report_t expected_reports[$];
  stim_row_t    directed_rows[$];

  int mismatches = 0;
  int polls_sent = 0;
  int reports_seen = 0;
  int cfg_writes = 0;
  int cycle_cnt = 0;

  // Sender pacing: bursts of back-to-back polls separated by random gaps.
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // Receiver pacing: a stall mode that is redrawn whenever its hold count runs out.
  int ready_mode = 0;
  int ready_hold = 0;

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // Advance every button by one poll and build the report the block should
  // give. Elapsed time is a plain 32-bit difference, so wrap takes care of
  // itself. The held time is read after the update.
  function automatic poll_report_t debounce_poll(input logic [NOW_W-1:0]  now,
                                                 input logic [MASK_W-1:0] pins,
                                                 input logic [SEL_W-1:0]  sel);
    poll_report_t     rep;
    logic             raw;
    logic [NOW_W-1:0] elapsed;
    int               i;
    rep = '0;
    for (i = 0; i < MASK_W; i++) begin
      raw = inj_mask_r[i] ? inj_level_r[i] : ~pins[i];
      elapsed = now - phase_t0[i];
      case (btn_phase[i])
        PH_IDLE: begin
          if (raw) begin
            btn_phase[i] = PH_SETTLE_DOWN;
            phase_t0[i] = now;
          end
        end
        PH_SETTLE_DOWN: begin
          if (!raw) begin
            btn_phase[i] = PH_IDLE;
          end else if (elapsed >= NOW_W'(debounce_ms)) begin
            btn_phase[i] = PH_DOWN;
            phase_t0[i] = now;
            press_t0[i] = now;
            rep.pressed[i] = 1'b1;
          end
        end
        PH_DOWN: begin
          if (!raw) begin
            btn_phase[i] = PH_SETTLE_UP;
            phase_t0[i] = now;
          end
        end
        default: begin
          // A bounce while settling up falls back to down and keeps the
          // original press time.
          if (raw) begin
            btn_phase[i] = PH_DOWN;
          end else if (elapsed >= NOW_W'(debounce_ms)) begin
            btn_phase[i] = PH_IDLE;
            phase_t0[i] = now;
            rep.released[i] = 1'b1;
          end
        end
      endcase
      rep.down[i] = (btn_phase[i] == PH_DOWN) || (btn_phase[i] == PH_SETTLE_UP);
    end
    if (sel < MASK_W) begin
      if (btn_phase[sel] == PH_DOWN || btn_phase[sel] == PH_SETTLE_UP) begin
        rep.held = now - press_t0[sel];
      end
    end
    return rep;
  endfunction

  function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.addr = addr;
    row.wdata = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_poll(input logic [NOW_W-1:0] now, input logic [MASK_W-1:0] pins,
                                   input logic [SEL_W-1:0] sel);
    stim_row_t row;
    row = '0;
    row.now = now;
    row.pins = pins;
    row.sel = sel;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_poll_exp(input logic [NOW_W-1:0] now,
                                       input logic [MASK_W-1:0] pins,
                                       input logic [SEL_W-1:0] sel,
                                       input logic [MASK_W-1:0] down,
                                       input logic [MASK_W-1:0] pressed,
                                       input logic [MASK_W-1:0] released,
                                       input logic [HELD_W-1:0] held);
    stim_row_t row;
    row = '0;
    row.now = now;
    row.pins = pins;
    row.sel = sel;
    row.typed = 1'b1;
    row.want = '{down: down, pressed: pressed, released: released, held: held};
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Present one poll and hold it until the block takes it. The predictor is
  // advanced at the accepting edge; a typed expectation, where the table has
  // one, is queued in place of the predicted report.
  task automatic send_poll(input logic [NOW_W-1:0] now, input logic [MASK_W-1:0] pins,
                           input logic [SEL_W-1:0] sel, input logic typed,
                           input poll_report_t want);
    poll_report_t model;
    in_tvalid <= 1'b1;
    in_tdata <= {sel, pins, now};
    do @(posedge clk); while (!in_tready);
    model = debounce_poll(now, pins, sel);
    expected_reports.push_back(typed ? want : model);
    polls_sent++;
  endtask

  // Called after each accepted poll. Valid only drops when a gap is taken,
  // so a poll that follows directly keeps valid high without a glitch.
  task automatic pace();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and let every outstanding report come back, so the block is
  // idle before the registers change.
  task automatic drain();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready. The trailing
  // edge is the idle phase that keeps psel from toggling twice in one step.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == reg_addr(REG_DEBOUNCE)) debounce_ms = data[DEB_W-1:0];
    else if (addr == reg_addr(REG_INJ_MASK)) inj_mask_r = data[MASK_W-1:0];
    else if (addr == reg_addr(REG_INJ_LEVEL)) inj_level_r = data[MASK_W-1:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  // Result checker. Outputs are read just after the edge, so the values seen
  // are the ones the handshake was made with.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ERROR unexpected report: expected none, actual 0x%0h", $time, out_tdata);
        mismatches++;
      end else begin
        poll_report_t want;
        want = expected_reports.pop_front();
        check_field("down_mask", 32'(want.down), 32'(out_tdata[4:0]));
        check_field("pressed_mask", 32'(want.pressed), 32'(out_tdata[9:5]));
        check_field("released_mask", 32'(want.released), 32'(out_tdata[14:10]));
        check_field("held_time", want.held, out_tdata[46:15]);
        reports_seen++;
      end
    end
  end

  // Receiver back-pressure. Mode 0 never stalls, the others stall at random,
  // on a fixed 3-of-5 pattern, or most of the time.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(64, 256);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (cycle_cnt % 5) < 3;
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("multi_button_debouncer_core test failed");
      $finish;
    end
  end

  initial begin
    int                ph;
    int                n;
    int                b;
    int                max_step;
    logic [DEB_W-1:0]  deb_pick;
    logic [MASK_W-1:0] lvl;
    logic [MASK_W-1:0] pins;
    logic [SEL_W-1:0]  sel;
    logic [NOW_W-1:0]  now;
    stim_row_t         row;

    // Directed table. It opens at the reset debounce time of 20 ms with no
    // injection. Button 0 presses, bounces while settling up and releases.
    add_poll_exp(32'd0,  5'h1F, 3'd0, 5'h00, 5'h00, 5'h00, 32'd0);
    add_poll_exp(32'd5,  5'h1E, 3'd0, 5'h00, 5'h00, 5'h00, 32'd0);
    add_poll_exp(32'd25, 5'h1E, 3'd0, 5'h01, 5'h01, 5'h00, 32'd0);
    add_poll_exp(32'd30, 5'h1E, 3'd0, 5'h01, 5'h00, 5'h00, 32'd5);
    add_poll_exp(32'd31, 5'h1F, 3'd0, 5'h01, 5'h00, 5'h00, 32'd6);
    add_poll_exp(32'd32, 5'h1E, 3'd0, 5'h01, 5'h00, 5'h00, 32'd7);
    add_poll_exp(32'd33, 5'h1F, 3'd0, 5'h01, 5'h00, 5'h00, 32'd8);
    add_poll_exp(32'd53, 5'h1F, 3'd0, 5'h00, 5'h00, 5'h01, 32'd0);
    // All pins low with an out-of-range select; buttons 1 and 3 let go while
    // settling down and must restart without an edge.
    add_poll_exp(32'd100, 5'h00, 3'd7, 5'h00, 5'h00, 5'h00, 32'd0);
    add_poll_exp(32'd110, 5'h0A, 3'd3, 5'h00, 5'h00, 5'h00, 32'd0);
    add_poll_exp(32'd120, 5'h00, 3'd5, 5'h15, 5'h15, 5'h00, 32'd0);
    add_poll_exp(32'd140, 5'h00, 3'd4, 5'h1F, 5'h0A, 5'h00, 32'd20);
    // Zero debounce: settling still costs one poll, even at the same time.
    // Upper bits of the written word must be dropped.
    add_cfg(reg_addr(REG_DEBOUNCE), 32'hFFFF_0000);
    add_poll_exp(32'd141, 5'h1F, 3'd2, 5'h1F, 5'h00, 5'h00, 32'd21);
    add_poll_exp(32'd141, 5'h1F, 3'd2, 5'h00, 5'h00, 5'h1F, 32'd0);
    add_poll_exp(32'd141, 5'h00, 3'd1, 5'h00, 5'h00, 5'h00, 32'd0);
    add_poll_exp(32'd141, 5'h00, 3'd1, 5'h1F, 5'h1F, 5'h00, 32'd0);
    // Injection on buttons 0, 2 and 4: first forced released, then pressed.
    add_cfg(reg_addr(REG_INJ_MASK), 32'hFFFF_FFF5);
    add_cfg(reg_addr(REG_INJ_LEVEL), 32'hA5A5_A5E0);
    add_poll_exp(32'd150, 5'h00, 3'd0, 5'h1F, 5'h00, 5'h00, 32'd9);
    add_poll_exp(32'd151, 5'h00, 3'd0, 5'h0A, 5'h00, 5'h15, 32'd0);
    add_cfg(reg_addr(REG_INJ_LEVEL), 32'h0000_001F);
    add_poll_exp(32'd160, 5'h1F, 3'd3, 5'h0A, 5'h00, 5'h00, 32'd19);
    // The unused word address must not disturb anything; then the longest
    // debounce time across a timestamp wrap.
    add_cfg(ADDR_SPARE, 32'h0000_FFFF);
    add_cfg(reg_addr(REG_DEBOUNCE), 32'h0000_FFFF);
    add_poll_exp(32'hFFFF_FFF0, 5'h1F, 3'd0, 5'h15, 5'h15, 5'h0A, 32'd0);
    add_poll_exp(32'h0000_FFEE, 5'h1F, 3'd0, 5'h15, 5'h00, 5'h00, 32'h0000_FFFE);
    add_cfg(reg_addr(REG_INJ_MASK), 32'h0000_0000);
    add_poll_exp(32'h0001_0000, 5'h1F, 3'd4, 5'h15, 5'h00, 5'h00, 32'h0001_0010);
    add_poll_exp(32'h0001_FFFF, 5'h1F, 3'd4, 5'h00, 5'h00, 5'h15, 32'd0);
    add_poll(32'd200000, 5'h15, 3'd2);
    add_poll(32'hFFFF_FFFF, 5'h0A, 3'd3);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < directed_rows.size(); n++) begin
      row = directed_rows[n];
      if (row.is_cfg) begin
        drain();
        cfg_write(row.addr, row.wdata);
      end else begin
        send_poll(row.now, row.pins, row.sel, row.typed, row.want);
        pace();
      end
    end

    // Random phases. Each one picks a debounce time and injection setting,
    // then plays per-button press and release sequences: levels that hold
    // for several polls with time steps scaled to the debounce time, mixed
    // with bursts of chatter and the odd huge time jump.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph == 0) deb_pick = '0;
      else if (ph == 1) deb_pick = 16'hFFFF;
      else if (ph == 2) deb_pick = 16'd1;
      else if ($urandom_range(0, 3) == 0) deb_pick = DEB_W'($urandom_range(0, 65535));
      else deb_pick = DEB_W'($urandom_range(2, 40));
      cfg_write(reg_addr(REG_DEBOUNCE), ($urandom & 32'hFFFF_0000) | 32'(deb_pick));
      cfg_write(reg_addr(REG_INJ_MASK),
                ($urandom & 32'hFFFF_FFE0) |
                (($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(0, 31))));
      cfg_write(reg_addr(REG_INJ_LEVEL), $urandom);
      if (ph == 3) cfg_write(ADDR_SPARE, $urandom);

      gaps_on = ($urandom_range(0, 3) != 0);
      max_step = int'(deb_pick) / 2 + 2;
      if ($urandom_range(0, 2) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 5 * max_step + 100);
      else now = $urandom;
      lvl = MASK_W'($urandom_range(0, 31));

      for (n = 0; n < POLLS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          pins = MASK_W'($urandom_range(0, 31));
        end else begin
          for (b = 0; b < MASK_W; b++) begin
            if ($urandom_range(0, 9) == 0) lvl[b] = ~lvl[b];
          end
          pins = lvl;
        end
        if ($urandom_range(0, 63) == 0) now = now + $urandom;
        else now = now + $urandom_range(0, max_step);
        if ($urandom_range(0, 4) == 0) sel = SEL_W'($urandom_range(0, 7));
        else sel = SEL_W'($urandom_range(0, MASK_W - 1));
        send_poll(now, pins, sel, 1'b0, '0);
        pace();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Summary: %0d polls sent, %0d reports checked, %0d register writes.",
             polls_sent, reports_seen, cfg_writes);
    $display("Covered debounce times from 0 to 65535, pin injection and timestamp wrap.");
    if (mismatches == 0) begin
      $display("multi_button_debouncer_core test passed");
    end else begin
      $display("multi_button_debouncer_core test failed");
    end
    $finish;
  end

endmodule
